// ===== sv/pbm_ascii_bitmap_parser_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef PBM_ASCII_BITMAP_PARSER_MACROS_SVH
`define PBM_ASCII_BITMAP_PARSER_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define PBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pbm_checker: property violated");

// Clocked property that is also checked across reset.
`define PBM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pbm_checker: property violated");

`endif

// ===== sv/pbm_pkg.sv =====
package pbm_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_M0       = 4'd0,
    PH_M1       = 4'd1,
    PH_M2       = 4'd2,
    PH_WCHECK   = 4'd3,
    PH_WCOMMENT = 4'd4,
    PH_WSKIP    = 4'd5,
    PH_WDIGITS  = 4'd6,
    PH_HCHECK   = 4'd7,
    PH_HCOMMENT = 4'd8,
    PH_HSKIP    = 4'd9,
    PH_HDIGITS  = 4'd10,
    PH_PIX      = 4'd11,
    PH_PCOMMENT = 4'd12,
    PH_ERR      = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_ERROR  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_WIDTH  = 3'd2,
    ERR_HEIGHT = 3'd3,
    ERR_MANY   = 3'd4,
    ERR_FEW    = 3'd5
  } err_code_e;

  typedef logic [12:0] dim_t;

  typedef struct packed {
    res_kind_e kind;
    logic [7:0] pixel;
    dim_t       width;
    dim_t       height;
    err_code_e  err;
    logic       last;
  } res_t;

  // Up to two results per byte go into the result queue together
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
  } push_t;

  localparam int unsigned RES_DEPTH = 4;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] PIX_ON   = 8'hFF;
  localparam logic [7:0] PIX_OFF  = 8'h00;

  function automatic res_t make_err(input err_code_e code);
    res_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.err  = code;
    return r;
  endfunction

  function automatic res_t make_hdr(input dim_t w, input dim_t h);
    res_t r;
    r = '0;
    r.kind   = KIND_HEADER;
    r.width  = w;
    r.height = h;
    return r;
  endfunction

  function automatic res_t make_pix(input logic [7:0] v);
    res_t r;
    r = '0;
    r.kind  = KIND_PIXEL;
    r.pixel = v;
    return r;
  endfunction

  function automatic res_t make_accept();
    res_t r;
    r = '0;
    r.kind = KIND_ACCEPT;
    return r;
  endfunction

endpackage

// ===== sv/pbm_stream_if.sv =====
interface pbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_file;

  modport source (output valid, output in_byte, output end_of_file, input ready);
  modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface pbm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  pixel_value;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [2:0]  error_code;
  logic        run_last;

  modport source (
    output valid, output result_kind, output pixel_value, output image_width,
    output image_height, output error_code, output run_last, input ready
  );
  modport sink (
    input valid, input result_kind, input pixel_value, input image_width,
    input image_height, input error_code, input run_last, output ready
  );
endinterface

// ===== sv/pbm_parse.sv =====
module pbm_parse #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_eof_i,
  output logic              in_ready_o,
  input  logic              room_i,
  output pbm_pkg::push_t    push_o
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NW   = (WW > HW) ? WW : HW;
  localparam int unsigned ACCW = NW + 4;
  localparam int unsigned TW   = WW + HW;

  // Input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       advance;

  pbm_pkg::phase_e phase_q, phase_d, ph1;
  logic [NW-1:0]   accum_q, accum_d, acc1;
  logic [WW-1:0]   width_q, width_d;
  logic [TW-1:0]   total_q, total_d;
  logic [TW-1:0]   count_q, count_d, count1;

  logic [ACCW-1:0] acc_base, acc_next;
  logic            is_dig, is_sp, is_hash, is_lf, is_cr, is_bit;
  logic            gt_w, gt_h, acc1_zero;

  pbm_pkg::err_code_e fail_p, fail_e;
  logic               dig_load, wid_load, hdr_p, pix_p, hdr_e, acc_e;

  pbm_pkg::res_t pa, ea, eb, r0, r1;
  logic          pa_v, ea_v, eb_v;
  logic [1:0]    num;

  assign advance    = in_vld_q && room_i;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      eof_q  <= in_eof_i;
    end
  end

  // Character classes
  assign is_dig  = (byte_q >= pbm_pkg::CH_ZERO) && (byte_q <= pbm_pkg::CH_NINE);
  assign is_sp   = (byte_q == pbm_pkg::CH_SPACE) ||
                   ((byte_q >= pbm_pkg::CH_TAB) && (byte_q <= pbm_pkg::CH_CR));
  assign is_hash = (byte_q == pbm_pkg::CH_HASH);
  assign is_lf   = (byte_q == pbm_pkg::CH_LF);
  assign is_cr   = (byte_q == pbm_pkg::CH_CR);
  assign is_bit  = (byte_q == pbm_pkg::CH_ZERO) || (byte_q == pbm_pkg::CH_ONE);

  // Decimal accumulate: a first digit starts from zero
  assign acc_base = ((phase_q == pbm_pkg::PH_WDIGITS) || (phase_q == pbm_pkg::PH_HDIGITS)) ?
                    ACCW'(accum_q) : '0;
  assign acc_next = acc_base * ACCW'(10) + ACCW'(byte_q[3:0]);
  assign gt_w     = acc_next > ACCW'(MAX_WIDTH);
  assign gt_h     = acc_next > ACCW'(MAX_HEIGHT);

  assign acc1      = dig_load ? acc_next[NW-1:0] : accum_q;
  assign acc1_zero = (acc1 == '0);
  assign count1    = count_q + TW'(pix_p);

  // Decode and next phase
  always_comb begin
    ph1      = phase_q;
    fail_p   = pbm_pkg::ERR_NONE;
    dig_load = 1'b0;
    wid_load = 1'b0;
    hdr_p    = 1'b0;
    pix_p    = 1'b0;
    unique case (phase_q)
      pbm_pkg::PH_M0: begin
        if (byte_q == pbm_pkg::CH_P) ph1 = pbm_pkg::PH_M1;
        else if (!is_cr) fail_p = pbm_pkg::ERR_MAGIC;
      end
      pbm_pkg::PH_M1: begin
        if (byte_q == pbm_pkg::CH_ONE) ph1 = pbm_pkg::PH_M2;
        else if (!is_cr) fail_p = pbm_pkg::ERR_MAGIC;
      end
      pbm_pkg::PH_M2: begin
        if (is_lf) ph1 = pbm_pkg::PH_WCHECK;
        else if (!is_cr) fail_p = pbm_pkg::ERR_MAGIC;
      end
      pbm_pkg::PH_WCHECK, pbm_pkg::PH_WSKIP: begin
        if (is_hash && (phase_q == pbm_pkg::PH_WCHECK)) begin
          ph1 = pbm_pkg::PH_WCOMMENT;
        end else if (is_sp) begin
          ph1 = pbm_pkg::PH_WSKIP;
        end else if (is_dig) begin
          dig_load = 1'b1;
          ph1      = pbm_pkg::PH_WDIGITS;
          if (gt_w) fail_p = pbm_pkg::ERR_WIDTH;
        end else begin
          fail_p = pbm_pkg::ERR_WIDTH;
        end
      end
      pbm_pkg::PH_WCOMMENT: begin
        if (is_lf) ph1 = pbm_pkg::PH_WCHECK;
      end
      pbm_pkg::PH_WDIGITS: begin
        if (is_dig) begin
          dig_load = 1'b1;
          if (gt_w) fail_p = pbm_pkg::ERR_WIDTH;
        end else if (accum_q == '0) begin
          fail_p = pbm_pkg::ERR_WIDTH;
        end else begin
          // Terminator is reparsed as the first byte before the height
          wid_load = 1'b1;
          if (is_hash) ph1 = pbm_pkg::PH_HCOMMENT;
          else if (is_sp) ph1 = pbm_pkg::PH_HSKIP;
          else fail_p = pbm_pkg::ERR_HEIGHT;
        end
      end
      pbm_pkg::PH_HCHECK, pbm_pkg::PH_HSKIP: begin
        if (is_hash && (phase_q == pbm_pkg::PH_HCHECK)) begin
          ph1 = pbm_pkg::PH_HCOMMENT;
        end else if (is_sp) begin
          ph1 = pbm_pkg::PH_HSKIP;
        end else if (is_dig) begin
          dig_load = 1'b1;
          ph1      = pbm_pkg::PH_HDIGITS;
          if (gt_h) fail_p = pbm_pkg::ERR_HEIGHT;
        end else begin
          fail_p = pbm_pkg::ERR_HEIGHT;
        end
      end
      pbm_pkg::PH_HCOMMENT: begin
        if (is_lf) ph1 = pbm_pkg::PH_HCHECK;
      end
      pbm_pkg::PH_HDIGITS: begin
        if (is_dig) begin
          dig_load = 1'b1;
          if (gt_h) fail_p = pbm_pkg::ERR_HEIGHT;
        end else if (accum_q == '0) begin
          fail_p = pbm_pkg::ERR_HEIGHT;
        end else begin
          // Header done; terminator is reparsed as pixel data
          hdr_p = 1'b1;
          ph1   = is_hash ? pbm_pkg::PH_PCOMMENT : pbm_pkg::PH_PIX;
        end
      end
      pbm_pkg::PH_PIX: begin
        if (is_hash) begin
          ph1 = pbm_pkg::PH_PCOMMENT;
        end else if (is_bit) begin
          if (count_q >= total_q) fail_p = pbm_pkg::ERR_MANY;
          else pix_p = 1'b1;
        end
      end
      pbm_pkg::PH_PCOMMENT: begin
        if (is_lf) ph1 = pbm_pkg::PH_PIX;
      end
      default: ;
    endcase
    if (fail_p != pbm_pkg::ERR_NONE) ph1 = pbm_pkg::PH_ERR;

    // End of file, judged on the phase this byte reaches
    fail_e = pbm_pkg::ERR_NONE;
    hdr_e  = 1'b0;
    acc_e  = 1'b0;
    if (eof_q) begin
      unique case (ph1) inside
        pbm_pkg::PH_M0, pbm_pkg::PH_M1: fail_e = pbm_pkg::ERR_MAGIC;
        pbm_pkg::PH_M2, pbm_pkg::PH_WCHECK, pbm_pkg::PH_WCOMMENT, pbm_pkg::PH_WSKIP:
          fail_e = pbm_pkg::ERR_WIDTH;
        pbm_pkg::PH_WDIGITS:
          fail_e = acc1_zero ? pbm_pkg::ERR_WIDTH : pbm_pkg::ERR_HEIGHT;
        pbm_pkg::PH_HCHECK, pbm_pkg::PH_HCOMMENT, pbm_pkg::PH_HSKIP:
          fail_e = pbm_pkg::ERR_HEIGHT;
        pbm_pkg::PH_HDIGITS: begin
          // A complete height still yields the header, but no pixel can follow
          if (acc1_zero) begin
            fail_e = pbm_pkg::ERR_HEIGHT;
          end else begin
            hdr_e  = 1'b1;
            fail_e = pbm_pkg::ERR_FEW;
          end
        end
        pbm_pkg::PH_PIX, pbm_pkg::PH_PCOMMENT: begin
          if (hdr_p || (count1 != total_q)) fail_e = pbm_pkg::ERR_FEW;
          else acc_e = 1'b1;
        end
        default: ;
      endcase
    end
    phase_d = eof_q ? pbm_pkg::PH_M0 : ph1;
  end

  // Result assembly
  always_comb begin
    pa   = '0;
    pa_v = 1'b1;
    if (fail_p != pbm_pkg::ERR_NONE) begin
      pa = pbm_pkg::make_err(fail_p);
    end else if (hdr_p) begin
      pa = pbm_pkg::make_hdr(pbm_pkg::dim_t'(width_q), pbm_pkg::dim_t'(acc1));
    end else if (pix_p) begin
      pa = pbm_pkg::make_pix((byte_q == pbm_pkg::CH_ONE) ? pbm_pkg::PIX_ON
                                                         : pbm_pkg::PIX_OFF);
    end else begin
      pa_v = 1'b0;
    end

    ea   = '0;
    ea_v = 1'b1;
    if (hdr_e) begin
      ea = pbm_pkg::make_hdr(pbm_pkg::dim_t'(width_q), pbm_pkg::dim_t'(acc1));
    end else if (fail_e != pbm_pkg::ERR_NONE) begin
      ea = pbm_pkg::make_err(fail_e);
    end else if (acc_e) begin
      ea = pbm_pkg::make_accept();
    end else begin
      ea_v = 1'b0;
    end

    eb   = pbm_pkg::make_err(pbm_pkg::ERR_FEW);
    eb_v = hdr_e;

    r0  = pa_v ? pa : ea;
    r1  = pa_v ? ea : eb;
    num = 2'(pa_v) + 2'(ea_v) + 2'(eb_v);
    if (num == 2'd1) r0.last = 1'b1;
    if (num == 2'd2) r1.last = 1'b1;

    push_o.num  = advance ? num : 2'd0;
    push_o.res0 = r0;
    push_o.res1 = r1;
  end

  // Running state
  always_comb begin
    if (eof_q) begin
      accum_d = '0;
      width_d = '0;
      total_d = '0;
      count_d = '0;
    end else begin
      accum_d = acc1;
      width_d = wid_load ? accum_q[WW-1:0] : width_q;
      total_d = hdr_p ? (TW'(width_q) * TW'(accum_q[HW-1:0])) : total_q;
      count_d = hdr_p ? '0 : count1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbm_pkg::PH_M0;
      accum_q <= '0;
      width_q <= '0;
      total_q <= '0;
      count_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      width_q <= width_d;
      total_q <= total_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/pbm_res_fifo.sv =====
module pbm_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pbm_pkg::push_t push_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output pbm_pkg::res_t  head_o
);

  localparam int unsigned PTRW = $clog2(pbm_pkg::RES_DEPTH);
  localparam int unsigned CNTW = $clog2(pbm_pkg::RES_DEPTH + 1);

  pbm_pkg::res_t   mem_q [pbm_pkg::RES_DEPTH];
  logic [PTRW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;
  // Room for a full pair of results, ignoring a same-cycle pop
  assign room_o  = cnt_q <= CNTW'(pbm_pkg::RES_DEPTH - 2);

  assign wr_ptr_d = wr_ptr_q + PTRW'(push_i.num);
  assign rd_ptr_d = rd_ptr_q + PTRW'(pop);
  assign cnt_d    = cnt_q + CNTW'(push_i.num) - CNTW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + PTRW'(1)] <= push_i.res1;
    end
  end

endmodule

// ===== sv/pbm_ascii_bitmap_parser.sv =====
// Plain PBM (P1) parser: takes the file text one byte per transfer on in_i,
// with end_of_file set on the last byte, and delivers on out_o the header
// dimensions once, one 0/255 pixel per '0'/'1' of the raster, then either a
// file-accepted result or an error (bad magic, width, height, too many or too
// few pixels); after an error the remaining bytes up to end of file are
// dropped, and every end-of-file byte returns the parser to its start state.
// The parse stage takes one byte per cycle while the queue has room; a byte
// is registered, then its results are written to the queue that feeds out_o.
// A byte can produce two results (header plus error, or a result plus the
// end-of-file verdict); these drain through a four-entry result queue at one
// per cycle while out_o is ready; the input stalls only when that queue lacks
// room for two. run_last marks the last result a byte produces. MAX_WIDTH and
// MAX_HEIGHT bound the accepted dimensions; pixel counting uses one registered
// width-times-height product taken when the header completes.
module pbm_ascii_bitmap_parser #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbm_in_if.sink    in_i,
  pbm_out_if.source out_o
);

  pbm_pkg::push_t push;
  pbm_pkg::res_t  head;
  logic           room;

  // Parse stage: input register, header/pixel state machine, result build
  pbm_parse #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_eof_i   (in_i.end_of_file),
    .in_ready_o (in_i.ready),
    .room_i     (room),
    .push_o     (push)
  );

  // Result queue: decouples the output handshake from parsing
  pbm_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.result_kind  = head.kind;
  assign out_o.pixel_value  = head.pixel;
  assign out_o.image_width  = head.width;
  assign out_o.image_height = head.height;
  assign out_o.error_code   = head.err;
  assign out_o.run_last     = head.last;

endmodule

// ===== sv/pbm_checker.sv =====
`include "pbm_ascii_bitmap_parser_macros.svh"

module pbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_i,
  input logic [7:0]  pixel_value_i,
  input logic [12:0] image_width_i,
  input logic [12:0] image_height_i,
  input logic [2:0]  error_code_i,
  input logic        run_last_i
);

  logic in_seen;
  assign in_seen = in_valid_i || !in_valid_i;

  // A stalled result holds every field
  `PBM_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_kind_i) &&
    $stable(pixel_value_i) && $stable(image_width_i) && $stable(image_height_i) &&
    $stable(error_code_i) && $stable(run_last_i))

  // Leaving reset: nothing pending on the output, input open
  `PBM_ASSERT_ALWAYS(a_reset_idle, clk_i,
    $rose(rst_ni) && in_seen |-> !out_valid_i && in_ready_i)

  // Accept and error end a byte's results
  `PBM_ASSERT(a_terminal_last, clk_i, rst_ni,
    out_valid_i && (result_kind_i == pbm_pkg::KIND_ERROR ||
    result_kind_i == pbm_pkg::KIND_ACCEPT) |-> run_last_i)

  // Pixels are black or white and carry no error or dimensions
  `PBM_ASSERT(a_pixel_clean, clk_i, rst_ni,
    out_valid_i && result_kind_i == pbm_pkg::KIND_PIXEL |->
    error_code_i == pbm_pkg::ERR_NONE && image_width_i == 13'd0 &&
    image_height_i == 13'd0 &&
    (pixel_value_i == pbm_pkg::PIX_ON || pixel_value_i == pbm_pkg::PIX_OFF))

endmodule

bind pbm_ascii_bitmap_parser pbm_checker u_pbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_kind_i  (out_o.result_kind),
  .pixel_value_i  (out_o.pixel_value),
  .image_width_i  (out_o.image_width),
  .image_height_i (out_o.image_height),
  .error_code_i   (out_o.error_code),
  .run_last_i     (out_o.run_last)
);

// ===== tb/sv/pbm_ascii_bitmap_parser_test.sv =====
`timescale 1ns / 1ps

module pbm_ascii_bitmap_parser_test;

  localparam int unsigned WIDTH_MAX    = 4096;
  localparam int unsigned HEIGHT_MAX   = 4096;
  // A byte's results pass the input register and the result queue; leave some margin.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int unsigned QUIET_LIMIT  = 4000;
  // Long receiver hold-off used to fill the result queue and stall the input.
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pbm_in_if  in_i ();
  pbm_out_if out_o ();

  pbm_ascii_bitmap_parser #(
    .MAX_WIDTH (WIDTH_MAX),
    .MAX_HEIGHT(HEIGHT_MAX)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Parser prediction: a private copy of the parse state, advanced on every
  // input transfer; the results each byte causes go into expected_results.
  // ---------------------------------------------------------------------------
  pbm_pkg::phase_e parse_ph;
  int unsigned     num_acc;     // wide enough for one digit past the limit
  pbm_pkg::dim_t   width_r;
  pbm_pkg::dim_t   height_r;
  logic [24:0]     pix_total;
  logic [24:0]     pix_count;
  pbm_pkg::res_t   byte_results[$];
  pbm_pkg::res_t   expected_results[$];

  int unsigned fails        = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;

  logic [7:0]  file_q[$];

  function automatic pbm_pkg::res_t result_of(pbm_pkg::res_kind_e k, logic [7:0] p,
                                              pbm_pkg::dim_t w, pbm_pkg::dim_t h,
                                              pbm_pkg::err_code_e e);
    pbm_pkg::res_t r;
    r.kind   = k;
    r.pixel  = p;
    r.width  = w;
    r.height = h;
    r.err    = e;
    r.last   = 1'b0;
    return r;
  endfunction

  // At most two results per byte; any further one is dropped.
  function automatic void add_result(pbm_pkg::res_t r);
    if (byte_results.size() < 2) begin
      byte_results = {byte_results, r};
    end
  endfunction

  function automatic void flag_error(pbm_pkg::err_code_e code);
    add_result(result_of(pbm_pkg::KIND_ERROR, pbm_pkg::PIX_OFF, '0, '0, code));
    parse_ph = pbm_pkg::PH_ERR;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == pbm_pkg::CH_SPACE || (b >= pbm_pkg::CH_TAB && b <= pbm_pkg::CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= pbm_pkg::CH_ZERO && b <= pbm_pkg::CH_NINE;
  endfunction

  // Flag on the digit that pushes the number past its maximum.
  function automatic void take_digit(logic [7:0] b, int unsigned limit,
                                     pbm_pkg::err_code_e code);
    num_acc = num_acc * 10 + int'(b - pbm_pkg::CH_ZERO);
    if (num_acc > limit) begin
      flag_error(code);
    end
  endfunction

  function automatic void close_header();
    height_r  = pbm_pkg::dim_t'(num_acc);
    pix_total = 25'(width_r) * 25'(height_r);
    pix_count = '0;
    add_result(result_of(pbm_pkg::KIND_HEADER, pbm_pkg::PIX_OFF, width_r, height_r,
                         pbm_pkg::ERR_NONE));
    parse_ph = pbm_pkg::PH_PIX;
  endfunction

  function automatic void close_raster();
    if (pix_count == pix_total) begin
      add_result(result_of(pbm_pkg::KIND_ACCEPT, pbm_pkg::PIX_OFF, '0, '0,
                           pbm_pkg::ERR_NONE));
    end else begin
      flag_error(pbm_pkg::ERR_FEW);
    end
  endfunction

  function automatic void reset_parser();
    parse_ph  = pbm_pkg::PH_M0;
    num_acc   = 0;
    width_r   = '0;
    height_r  = '0;
    pix_total = '0;
    pix_count = '0;
  endfunction

  function automatic void parse_pbm_byte(logic [7:0] b, logic eof);
    logic again;
    byte_results.delete();
    again = 1'b1;
    // A byte that ends a number is handed on to the next phase in the same step.
    while (again) begin
      again = 1'b0;
      case (parse_ph)
        pbm_pkg::PH_M0: begin
          if (b == pbm_pkg::CH_P) parse_ph = pbm_pkg::PH_M1;
          else if (b != pbm_pkg::CH_CR) flag_error(pbm_pkg::ERR_MAGIC);
        end
        pbm_pkg::PH_M1: begin
          if (b == pbm_pkg::CH_ONE) parse_ph = pbm_pkg::PH_M2;
          else if (b != pbm_pkg::CH_CR) flag_error(pbm_pkg::ERR_MAGIC);
        end
        pbm_pkg::PH_M2: begin
          if (b == pbm_pkg::CH_LF) parse_ph = pbm_pkg::PH_WCHECK;
          else if (b != pbm_pkg::CH_CR) flag_error(pbm_pkg::ERR_MAGIC);
        end
        pbm_pkg::PH_WCHECK, pbm_pkg::PH_WSKIP: begin
          if (b == pbm_pkg::CH_HASH && parse_ph == pbm_pkg::PH_WCHECK) begin
            parse_ph = pbm_pkg::PH_WCOMMENT;
          end else if (is_blank(b)) begin
            parse_ph = pbm_pkg::PH_WSKIP;
          end else if (is_digit(b)) begin
            num_acc  = 0;
            parse_ph = pbm_pkg::PH_WDIGITS;
            take_digit(b, WIDTH_MAX, pbm_pkg::ERR_WIDTH);
          end else begin
            flag_error(pbm_pkg::ERR_WIDTH);
          end
        end
        pbm_pkg::PH_WCOMMENT: begin
          if (b == pbm_pkg::CH_LF) parse_ph = pbm_pkg::PH_WCHECK;
        end
        pbm_pkg::PH_WDIGITS: begin
          if (is_digit(b)) begin
            take_digit(b, WIDTH_MAX, pbm_pkg::ERR_WIDTH);
          end else if (num_acc == 0) begin
            flag_error(pbm_pkg::ERR_WIDTH);
          end else begin
            width_r  = pbm_pkg::dim_t'(num_acc);
            parse_ph = pbm_pkg::PH_HCHECK;
            again    = 1'b1;
          end
        end
        pbm_pkg::PH_HCHECK, pbm_pkg::PH_HSKIP: begin
          if (b == pbm_pkg::CH_HASH && parse_ph == pbm_pkg::PH_HCHECK) begin
            parse_ph = pbm_pkg::PH_HCOMMENT;
          end else if (is_blank(b)) begin
            parse_ph = pbm_pkg::PH_HSKIP;
          end else if (is_digit(b)) begin
            num_acc  = 0;
            parse_ph = pbm_pkg::PH_HDIGITS;
            take_digit(b, HEIGHT_MAX, pbm_pkg::ERR_HEIGHT);
          end else begin
            flag_error(pbm_pkg::ERR_HEIGHT);
          end
        end
        pbm_pkg::PH_HCOMMENT: begin
          if (b == pbm_pkg::CH_LF) parse_ph = pbm_pkg::PH_HCHECK;
        end
        pbm_pkg::PH_HDIGITS: begin
          if (is_digit(b)) begin
            take_digit(b, HEIGHT_MAX, pbm_pkg::ERR_HEIGHT);
          end else if (num_acc == 0) begin
            flag_error(pbm_pkg::ERR_HEIGHT);
          end else begin
            close_header();
            again = 1'b1;
          end
        end
        pbm_pkg::PH_PIX: begin
          if (b == pbm_pkg::CH_HASH) begin
            parse_ph = pbm_pkg::PH_PCOMMENT;
          end else if (b == pbm_pkg::CH_ZERO || b == pbm_pkg::CH_ONE) begin
            if (pix_count >= pix_total) begin
              flag_error(pbm_pkg::ERR_MANY);
            end else begin
              add_result(result_of(pbm_pkg::KIND_PIXEL,
                                   (b == pbm_pkg::CH_ONE) ? pbm_pkg::PIX_ON
                                                          : pbm_pkg::PIX_OFF,
                                   '0, '0, pbm_pkg::ERR_NONE));
              pix_count++;
            end
          end
        end
        pbm_pkg::PH_PCOMMENT: begin
          if (b == pbm_pkg::CH_LF) parse_ph = pbm_pkg::PH_PIX;
        end
        default: ;
      endcase
    end

    // End of file: verdict for the phase reached, then back to the start state.
    if (eof) begin
      case (parse_ph)
        pbm_pkg::PH_M0, pbm_pkg::PH_M1: flag_error(pbm_pkg::ERR_MAGIC);
        pbm_pkg::PH_M2, pbm_pkg::PH_WCHECK, pbm_pkg::PH_WCOMMENT, pbm_pkg::PH_WSKIP:
          flag_error(pbm_pkg::ERR_WIDTH);
        pbm_pkg::PH_WDIGITS:
          flag_error((num_acc == 0) ? pbm_pkg::ERR_WIDTH : pbm_pkg::ERR_HEIGHT);
        pbm_pkg::PH_HCHECK, pbm_pkg::PH_HCOMMENT, pbm_pkg::PH_HSKIP:
          flag_error(pbm_pkg::ERR_HEIGHT);
        pbm_pkg::PH_HDIGITS: begin
          if (num_acc == 0) begin
            flag_error(pbm_pkg::ERR_HEIGHT);
          end else begin
            close_header();
            close_raster();
          end
        end
        pbm_pkg::PH_PIX, pbm_pkg::PH_PCOMMENT: close_raster();
        default: ;
      endcase
      reset_parser();
    end

    // Mark the final result of this byte.
    foreach (byte_results[i]) begin
      byte_results[i].last = (i == byte_results.size() - 1);
      expected_results = {expected_results, byte_results[i]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: predict on each input transfer, compare on each output transfer.
  // Both run in one process so a byte is always predicted before its results.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    pbm_pkg::res_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d error %0d",
               $time, out_o.result_kind, out_o.error_code);
      fails++;
      return;
    end
    want = expected_results.pop_front();
    check_field("result_kind", 13'(want.kind), 13'(out_o.result_kind));
    check_field("pixel_value", 13'(want.pixel), 13'(out_o.pixel_value));
    check_field("image_width", want.width, out_o.image_width);
    check_field("image_height", want.height, out_o.image_height);
    check_field("error_code", 13'(want.err), 13'(out_o.error_code));
    check_field("run_last", 13'(want.last), 13'(out_o.run_last));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        parse_pbm_byte(in_i.in_byte, in_i.end_of_file);
      end
      if (out_o.valid && out_o.ready) begin
        check_result();
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while rx_hold is set.
  always @(posedge clk_i) begin
    out_o.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pbm_ascii_bitmap_parser_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    tx_gap_pct = tx_pct;
    rx_stall_pct <= rx_pct;
  endtask

  // Offer one byte, idling first at random; return at the edge of its transfer
  // with valid still high so back-to-back bytes need no second assignment.
  task automatic send_byte(logic [7:0] b, logic eof);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid       <= 1'b1;
    in_i.in_byte     <= b;
    in_i.end_of_file <= eof;
    do @(posedge clk_i); while (!in_i.ready);
  endtask

  // Send the assembled file; end_of_file rides on its last byte.
  task automatic send_file();
    foreach (file_q[i]) begin
      send_byte(file_q[i], i == file_q.size() - 1);
    end
    bytes_sent += file_q.size();
    file_q.delete();
  endtask

  // Hold the sender until every expected result has come, then let the pipe settle.
  task automatic wait_drained();
    in_i.valid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Append one byte to the file being assembled.
  function automatic void put_byte(logic [7:0] c);
    file_q = {file_q, c};
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endfunction

  task automatic send_text(string s);
    put_str(s);
    send_file();
  endtask

  function automatic void put_blanks(int unsigned n);
    repeat (n) begin
      if ($urandom_range(2) == 0) put_byte(pbm_pkg::CH_SPACE);
      else put_byte(pbm_pkg::CH_TAB + 8'($urandom_range(4)));
    end
  endfunction

  // '#', a few arbitrary bytes other than LF, then LF.
  function automatic void put_comment();
    logic [7:0] c;
    put_byte(pbm_pkg::CH_HASH);
    repeat ($urandom_range(5)) begin
      c = 8'($urandom_range(255));
      if (c == pbm_pkg::CH_LF) c = pbm_pkg::CH_P;
      put_byte(c);
    end
    put_byte(pbm_pkg::CH_LF);
  endfunction

  // Decimal number with an occasional leading zero or stray sign.
  function automatic void put_number(int unsigned n);
    case ($urandom_range(29))
      0: put_byte(CH_MINUS);
      1: put_byte(CH_PLUS);
      2, 3: put_byte(pbm_pkg::CH_ZERO);
      default: ;
    endcase
    put_str($sformatf("%0d", n));
  endfunction

  // Pick a small dimension mostly, sometimes zero or near the limit.
  function automatic int unsigned pick_dim(int unsigned limit, int unsigned typical);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) return 0;
    if (pick < 9) return $urandom_range(limit - 4, limit + 4);
    return $urandom_range(1, typical);
  endfunction

  // A separator: blanks, or one or two comments followed by optional blanks.
  function automatic void put_separator();
    if ($urandom_range(3) == 0) begin
      put_comment();
      if ($urandom_range(1) == 0) put_comment();
      put_blanks($urandom_range(2));
    end else begin
      put_blanks($urandom_range(1, 2));
    end
  endfunction

  // Raster bytes with junk between pixels: blanks, comments, other bytes.
  function automatic void put_pixels(int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      case ($urandom_range(7))
        0: put_blanks(1);
        1: put_comment();
        2: begin
          c = 8'($urandom_range(255));
          if (c == pbm_pkg::CH_ZERO || c == pbm_pkg::CH_ONE || c == pbm_pkg::CH_HASH) begin
            c = pbm_pkg::CH_SPACE;
          end
          put_byte(c);
        end
        default: ;
      endcase
      put_byte($urandom_range(1) ? pbm_pkg::CH_ONE : pbm_pkg::CH_ZERO);
    end
  endfunction

  // Mostly well-formed files with random content; the rest noise, broken
  // magic lines, bad dimensions, wrong pixel counts and truncated files.
  function automatic void build_random_file();
    int unsigned pick, w, h, n_pix, keep;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
      return;
    end

    put_byte(pbm_pkg::CH_P);
    if ($urandom_range(5) == 0) put_byte(pbm_pkg::CH_CR);
    put_byte(pbm_pkg::CH_ONE);
    if ($urandom_range(3) == 0) put_byte(pbm_pkg::CH_CR);
    put_byte(pbm_pkg::CH_LF);
    if (pick < 12) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom_range(255));

    if ($urandom_range(3) == 0) put_comment();
    put_blanks($urandom_range(2));
    // A comment after whitespace is not allowed before the width.
    if ($urandom_range(49) == 0) put_comment();

    w = pick_dim(WIDTH_MAX, 6);
    h = pick_dim(HEIGHT_MAX, 5);
    put_number(w);
    put_separator();
    put_number(h);
    if (pick >= 95) return;  // end of file right on the height digits

    if ($urandom_range(2) == 0) put_comment();
    else put_blanks($urandom_range(1, 2));

    n_pix = w * h;
    if (n_pix > 48) n_pix = $urandom_range(12);
    else if (pick < 18) n_pix++;
    else if (pick < 24 && n_pix > 0) n_pix--;
    put_pixels(n_pix);
    if ($urandom_range(9) == 0) put_separator();

    if ($urandom_range(15) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Magic line: carriage returns, wrong characters, files ending inside it.
  task automatic test_magic_line();
    send_text("\015\015P\0151\015\n2\0151 #c\n10");
    send_text("Q");
    send_text("P");
    send_text("P2\n1 1 1");
    send_text("P1");
    wait_drained();
  endtask

  // Width and height: extremes, zero, overflow, signs, leading zeros.
  task automatic test_header_numbers();
    send_text("P1\n4096 4096");
    send_text("P1\n4096 1");
    send_text("P1\n4097 1 1");
    send_text("P1\n1 4097 1");
    send_text("P1\n0 1 1");
    send_text("P1\n1 0 1");
    send_text("P1\n-3 2 111111");
    send_text("P1\n3 +2 111111");
    send_text("P1\n007 01 1010101");
    send_text("P1\nx 1 1");
    wait_drained();
  endtask

  // Comments: allowed after the magic line and the width, and in the raster;
  // a '#' after whitespace in the header is an error.
  task automatic test_comments();
    send_text("P1\n#a\n#b\n3#x\n#y\n1\n# z\n101");
    send_text("P1\n #\n1 1 1");
    send_text("P1\n1 #\n1 1");
    send_text("P1\n1 1 1#c");
    wait_drained();
  endtask

  // Pixel count: exact, one too many, one too few, both pixel values.
  task automatic test_pixel_counts();
    send_text("P1\n1 1\n1");
    send_text("P1\n1 1 0");
    send_text("P1\n2 1 10");
    send_text("P1\n1 1 11 0");
    send_text("P1\n2 1 1");
    wait_drained();
  endtask

  // End of file after the magic line and inside the width and height fields.
  task automatic test_end_of_file();
    send_text("P1\n");
    send_text("P1\n#c");
    send_text("P1\n ");
    send_text("P1\n5");
    send_text("P1\n5 ");
    send_text("P1\n2 #c");
    send_text("P1\n5 0");
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering a dense raster, so the
  // result queue fills and the input stalls; the sender then waits for all.
  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    put_str("P1\n8 8\n");
    repeat (64) put_byte($urandom_range(1) ? pbm_pkg::CH_ONE : pbm_pkg::CH_ZERO);
    send_file();
    wait_drained();
  endtask

  task automatic test_random_files(int unsigned tx_pct, int unsigned rx_pct,
                                   int unsigned n_bytes);
    int unsigned start;
    set_idling(tx_pct, rx_pct);
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_random_file();
      send_file();
    end
    wait_drained();
  endtask

  initial begin
    in_i.valid       = 1'b0;
    in_i.in_byte     = '0;
    in_i.end_of_file = 1'b0;
    out_o.ready      = 1'b0;
    reset_parser();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_magic_line();
    test_header_numbers();
    test_comments();
    test_pixel_counts();
    test_end_of_file();
    test_backpressure();
    test_random_files(0, 0, 340);
    test_random_files(63, 0, 340);
    test_random_files(0, 63, 340);
    test_random_files(26, 26, 340);

    if (fails == 0) begin
      $display("pbm_ascii_bitmap_parser_test OK");
    end else begin
      $display("pbm_ascii_bitmap_parser_test NOT OK");
    end
    $finish;
  end

endmodule
